FILE: rtl/pcs_pkg.sv
package pcs_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int DT_W     = 16;
    localparam int SUM_W    = 48;
    localparam int ACC_W    = 64;
    localparam int FRAC_W   = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam int ERR_W    = SAMPLE_W + 1;
    localparam int DIFF_W   = SAMPLE_W + 2;
    localparam int QUO_W    = DIFF_W - 1;
    localparam int DER_W    = DIFF_W;
    localparam int CHUNK_W  = SUM_W / 3;
    localparam int RAW_W    = ACC_W - FRAC_W;

    // shared multiplier operand widths
    localparam int MA_W = DIFF_W;
    localparam int MB_W = GAIN_W + 1;
    localparam int PR_W = MA_W + MB_W;

    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING = 3'd4;

    // multiplier operand selects
    localparam logic [2:0] MUL_NONE = 3'd0;
    localparam logic [2:0] MUL_ED   = 3'd1;
    localparam logic [2:0] MUL_P    = 3'd2;
    localparam logic [2:0] MUL_I0   = 3'd3;
    localparam logic [2:0] MUL_I1   = 3'd4;
    localparam logic [2:0] MUL_I2   = 3'd5;
    localparam logic [2:0] MUL_D    = 3'd6;

    // accumulate shift selects, in units of one chunk
    localparam logic [1:0] SH_0 = 2'd0;
    localparam logic [1:0] SH_1 = 2'd1;
    localparam logic [1:0] SH_2 = 2'd2;

    typedef struct packed {
        logic       load;
        logic       div_init;
        logic       div_step;
        logic       integ;
        logic       deriv_load;
        logic [2:0] mul_sel;
        logic       acc_clr;
        logic       acc_add;
        logic [1:0] acc_shift;
        logic       finish;
    } t_cmd;

endpackage

FILE: rtl/pcs_ctrl.sv
module pcs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output pcs_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOAD = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_MP   = 4'd3;
    localparam logic [3:0] S_MI0  = 4'd4;
    localparam logic [3:0] S_MI1  = 4'd5;
    localparam logic [3:0] S_MI2  = 4'd6;
    localparam logic [3:0] S_MD   = 4'd7;
    localparam logic [3:0] S_ACC  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0]                 r_state, n_state;
    logic [pcs_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                       r_out_valid, n_out_valid;

    assign o_in_ready  = i_rst_n && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.mul_sel   = pcs_pkg::MUL_NONE;
        o_cmd.acc_shift = pcs_pkg::SH_0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.mul_sel  = pcs_pkg::MUL_ED;
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                // error*elapsed product lands in the first divide cycle
                o_cmd.integ    = (r_cnt == '0);
                if (r_cnt == pcs_pkg::CNT_W'(pcs_pkg::DIV_STEPS - 1)) begin
                    n_state = S_MP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MP: begin
                o_cmd.mul_sel    = pcs_pkg::MUL_P;
                o_cmd.acc_clr    = 1'b1;
                o_cmd.deriv_load = 1'b1;
                n_state          = S_MI0;
            end
            S_MI0: begin
                o_cmd.mul_sel   = pcs_pkg::MUL_I0;
                o_cmd.acc_add   = 1'b1;
                o_cmd.acc_shift = pcs_pkg::SH_0;
                n_state         = S_MI1;
            end
            S_MI1: begin
                o_cmd.mul_sel   = pcs_pkg::MUL_I1;
                o_cmd.acc_add   = 1'b1;
                o_cmd.acc_shift = pcs_pkg::SH_0;
                n_state         = S_MI2;
            end
            S_MI2: begin
                o_cmd.mul_sel   = pcs_pkg::MUL_I2;
                o_cmd.acc_add   = 1'b1;
                o_cmd.acc_shift = pcs_pkg::SH_1;
                n_state         = S_MD;
            end
            S_MD: begin
                o_cmd.mul_sel   = pcs_pkg::MUL_D;
                o_cmd.acc_add   = 1'b1;
                o_cmd.acc_shift = pcs_pkg::SH_2;
                n_state         = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_add   = 1'b1;
                o_cmd.acc_shift = pcs_pkg::SH_0;
                n_state         = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/pcs_dp.sv
module pcs_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pcs_pkg::t_cmd                   i_cmd,
    input  logic [pcs_pkg::SAMPLE_W-1:0]    i_target,
    input  logic [pcs_pkg::SAMPLE_W-1:0]    i_measured,
    input  logic [pcs_pkg::DT_W-1:0]        i_elapsed,
    input  logic                            i_cfg_we,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pcs_pkg::CFG_W-1:0]       i_cfg_data,
    output logic [pcs_pkg::SAMPLE_W-1:0]    o_drive,
    output logic                            o_limited
);

    localparam int SW = pcs_pkg::SAMPLE_W;
    localparam int GW = pcs_pkg::GAIN_W;

    // configuration
    logic [GW-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic [SW-1:0] r_floor, r_ceiling;

    // loop state
    logic signed [pcs_pkg::ERR_W-1:0] r_last_err;
    logic signed [pcs_pkg::SUM_W-1:0] r_sum;

    // per-item working registers
    logic signed [pcs_pkg::ERR_W-1:0] r_err;
    logic [pcs_pkg::DT_W-1:0]         r_dt;
    logic [pcs_pkg::DT_W-1:0]         r_rem;
    logic [pcs_pkg::QUO_W-1:0]        r_quo;
    logic                             r_neg;
    logic signed [pcs_pkg::DER_W-1:0] r_deriv;
    logic signed [pcs_pkg::PR_W-1:0]  r_prod;
    logic signed [pcs_pkg::ACC_W-1:0] r_acc;
    logic [SW-1:0]                    r_drive;
    logic                             r_limited;

    logic signed [pcs_pkg::ERR_W-1:0]  n_err;
    logic signed [pcs_pkg::DIFF_W-1:0] diff;
    logic [pcs_pkg::DIFF_W-1:0]        diff_mag;
    logic [pcs_pkg::DT_W:0]            trial;
    logic                              trial_ge;
    logic [pcs_pkg::DT_W:0]            trial_sub;
    logic signed [pcs_pkg::MA_W-1:0]   mul_a;
    logic signed [pcs_pkg::MB_W-1:0]   mul_b;
    logic signed [pcs_pkg::SUM_W:0]    sum_ext;
    logic signed [pcs_pkg::SUM_W-1:0]  sum_sat;
    logic signed [pcs_pkg::ACC_W-1:0]  prod_ext;
    logic signed [pcs_pkg::ACC_W-1:0]  prod_sh;
    logic signed [pcs_pkg::RAW_W-1:0]  raw;
    logic signed [pcs_pkg::RAW_W-1:0]  ceil_ext;
    logic signed [pcs_pkg::RAW_W-1:0]  floor_ext;
    logic signed [pcs_pkg::RAW_W-1:0]  drv_ext;
    logic [SW-1:0]                     drv;

    assign n_err = $signed({i_measured[SW-1], i_measured})
                 - $signed({i_target[SW-1], i_target});

    // restoring divider on magnitudes
    assign diff     = $signed({r_err[pcs_pkg::ERR_W-1], r_err})
                    - $signed({r_last_err[pcs_pkg::ERR_W-1], r_last_err});
    assign diff_mag = diff[pcs_pkg::DIFF_W-1] ? pcs_pkg::DIFF_W'(-diff)
                                              : pcs_pkg::DIFF_W'(diff);
    assign trial     = {r_rem, r_quo[pcs_pkg::QUO_W-1]};
    assign trial_ge  = (trial >= {1'b0, r_dt});
    assign trial_sub = trial - {1'b0, r_dt};

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_sel)
            pcs_pkg::MUL_ED: begin
                mul_a = pcs_pkg::MA_W'(r_err);
                mul_b = $signed({{(pcs_pkg::MB_W - pcs_pkg::DT_W){1'b0}}, r_dt});
            end
            pcs_pkg::MUL_P: begin
                mul_a = pcs_pkg::MA_W'(r_err);
                mul_b = pcs_pkg::MB_W'($signed(r_gain_p));
            end
            pcs_pkg::MUL_I0: begin
                mul_a = $signed({{(pcs_pkg::MA_W - pcs_pkg::CHUNK_W){1'b0}},
                                 r_sum[pcs_pkg::CHUNK_W-1:0]});
                mul_b = pcs_pkg::MB_W'($signed(r_gain_i));
            end
            pcs_pkg::MUL_I1: begin
                mul_a = $signed({{(pcs_pkg::MA_W - pcs_pkg::CHUNK_W){1'b0}},
                                 r_sum[2*pcs_pkg::CHUNK_W-1:pcs_pkg::CHUNK_W]});
                mul_b = pcs_pkg::MB_W'($signed(r_gain_i));
            end
            pcs_pkg::MUL_I2: begin
                // top chunk carries the sign
                mul_a = $signed({{(pcs_pkg::MA_W - pcs_pkg::CHUNK_W)
                                  {r_sum[pcs_pkg::SUM_W-1]}},
                                 r_sum[pcs_pkg::SUM_W-1:2*pcs_pkg::CHUNK_W]});
                mul_b = pcs_pkg::MB_W'($signed(r_gain_i));
            end
            pcs_pkg::MUL_D: begin
                mul_a = pcs_pkg::MA_W'(r_deriv);
                mul_b = pcs_pkg::MB_W'($signed(r_gain_d));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // saturating integral update
    always_comb begin
        sum_ext = $signed({r_sum[pcs_pkg::SUM_W-1], r_sum})
                + (pcs_pkg::SUM_W+1)'(r_prod);
        if (sum_ext[pcs_pkg::SUM_W] != sum_ext[pcs_pkg::SUM_W-1]) begin
            sum_sat = sum_ext[pcs_pkg::SUM_W]
                    ? $signed({1'b1, {(pcs_pkg::SUM_W-1){1'b0}}})
                    : $signed({1'b0, {(pcs_pkg::SUM_W-1){1'b1}}});
        end else begin
            sum_sat = sum_ext[pcs_pkg::SUM_W-1:0];
        end
    end

    always_comb begin
        prod_ext = pcs_pkg::ACC_W'(r_prod);
        case (i_cmd.acc_shift)
            pcs_pkg::SH_0: prod_sh = prod_ext;
            pcs_pkg::SH_1: prod_sh = prod_ext <<< pcs_pkg::CHUNK_W;
            pcs_pkg::SH_2: prod_sh = prod_ext <<< (2 * pcs_pkg::CHUNK_W);
            default:       prod_sh = prod_ext;
        endcase
    end

    // drop the Q8.8 fraction (floor), then clamp: ceiling wins over floor
    always_comb begin
        raw       = r_acc[pcs_pkg::ACC_W-1:pcs_pkg::FRAC_W];
        ceil_ext  = pcs_pkg::RAW_W'($signed(r_ceiling));
        floor_ext = pcs_pkg::RAW_W'($signed(r_floor));
        if (raw >= ceil_ext) begin
            drv = r_ceiling;
        end else if (raw <= floor_ext) begin
            drv = r_floor;
        end else begin
            drv = raw[SW-1:0];
        end
        drv_ext = pcs_pkg::RAW_W'($signed(drv));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p   <= '0;
            r_gain_i   <= '0;
            r_gain_d   <= '0;
            r_floor    <= {1'b1, {(SW-1){1'b0}}};
            r_ceiling  <= {1'b0, {(SW-1){1'b1}}};
            r_last_err <= '0;
            r_sum      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pcs_pkg::REG_GAIN_P:  r_gain_p  <= i_cfg_data[GW-1:0];
                    pcs_pkg::REG_GAIN_I:  r_gain_i  <= i_cfg_data[GW-1:0];
                    pcs_pkg::REG_GAIN_D:  r_gain_d  <= i_cfg_data[GW-1:0];
                    pcs_pkg::REG_FLOOR:   r_floor   <= i_cfg_data[SW-1:0];
                    pcs_pkg::REG_CEILING: r_ceiling <= i_cfg_data[SW-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.integ) begin
                r_sum <= sum_sat;
            end
            if (i_cmd.finish) begin
                r_last_err <= r_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_cmd.load) begin
            r_err <= n_err;
            r_dt  <= i_elapsed;
        end
        if (i_cmd.div_init) begin
            r_neg <= diff[pcs_pkg::DIFF_W-1];
            r_quo <= diff_mag[pcs_pkg::QUO_W-1:0];
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? trial_sub[pcs_pkg::DT_W-1:0] : trial[pcs_pkg::DT_W-1:0];
            r_quo <= {r_quo[pcs_pkg::QUO_W-2:0], trial_ge};
        end
        if (i_cmd.deriv_load) begin
            if (r_dt == '0) begin
                r_deriv <= '0;
            end else if (r_neg) begin
                r_deriv <= -$signed({1'b0, r_quo});
            end else begin
                r_deriv <= $signed({1'b0, r_quo});
            end
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + prod_sh;
        end
        if (i_cmd.finish) begin
            r_drive   <= drv;
            r_limited <= (drv_ext != raw);
        end
    end

    assign o_drive   = r_drive;
    assign o_limited = r_limited;

endmodule

FILE: rtl/pid_controller_step.sv
// PID step with saturating 48-bit integral and clamped drive. Each transaction
// on the slave side carries target, measured and elapsed ticks; one result
// (drive, limited) follows on the master side. An item passes from acceptance
// to a loaded result through a load step, the radix-2 divider that forms the
// derivative, the steps of the single shared 18x17 multiplier (proportional
// term, three 16-bit slices of the integral times its gain, derivative term,
// final add) and a clamp step. A new item is accepted once the previous one
// has been handed to the output register, so a waiting result does not block
// the next input. Gains are signed Q8.8; the user is to write the
// configuration only while the block is idle, which the block itself does not
// enforce, and indexes beyond the ceiling register are ignored.
module pid_controller_step (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] target, [31:16] measured, [47:32] elapsed
    input  logic [47:0]                     s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [15:0] drive
    output logic [15:0]                     m_axis_tdata,
    // [0] limited
    output logic [0:0]                      m_axis_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pcs_pkg::CFG_W-1:0]       i_cfg_data
);

    pcs_pkg::t_cmd cmd;
    logic          limited;

    assign o_cfg_ready = i_rst_n;

    pcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    pcs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_target    (s_axis_tdata[15:0]),
        .i_measured  (s_axis_tdata[31:16]),
        .i_elapsed   (s_axis_tdata[47:32]),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_drive     (m_axis_tdata),
        .o_limited   (limited)
    );

    assign m_axis_tuser = limited;

endmodule

FILE: rtl/pcs_checker.sv
module pcs_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [47:0]                     s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [15:0]                     m_axis_tdata,
    input logic [0:0]                      m_axis_tuser,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [pcs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [pcs_pkg::CFG_W-1:0]       i_cfg_data
);

    logic       in_acc, out_acc;
    logic [1:0] r_pending;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // items accepted whose result has not left yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input accepted while previous item still in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pending != 2'd0)
        else $error("result without an accepted item");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("more than two items in flight");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write stalled out of reset");

endmodule

bind pid_controller_step pcs_checker u_pcs_checker (.*);
